FILE: rtl/debounced_toggle_auto_off_top_assert.svh
// assertion macros for the debounced toggle block
// used by debounced_toggle_auto_off_top, needs a clock and a reset name
`ifndef DEBOUNCED_TOGGLE_AUTO_OFF_TOP_ASSERT_SVH
`define DEBOUNCED_TOGGLE_AUTO_OFF_TOP_ASSERT_SVH

// same-cycle implication
`define DTAO_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dtao assertion failed");

// next-cycle implication
`define DTAO_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dtao assertion failed");

`endif

FILE: rtl/dtao_pkg.sv
// shared types, register codes and helpers for the debounced toggle block
// no dependencies
`default_nettype none

package dtao_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_MS    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_INPUT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 8'd3;

  localparam logic [15:0] DEBOUNCE_MS_RST = 16'd150;
  localparam logic [31:0] ON_TIME_MS_RST  = 32'd60000;

  typedef struct packed {
    logic        raw_level;
    logic        remote_press;
    logic [15:0] elapsed_ms;
  } dtao_in_t;

  typedef struct packed {
    logic light_drive;
    logic toggle_pulse;
    logic debounced_press;
  } dtao_out_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [31:0] on_time_ms;
    logic        invert_input;
    logic        invert_output;
  } dtao_cfg_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtao_cfg_regs.sv
// configuration registers of the debounced toggle block
// depends on dtao_pkg
`default_nettype none

module dtao_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [dtao_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [dtao_pkg::CFG_DATA_W-1:0] wr_data,
  output dtao_pkg::dtao_cfg_t                 cfg
);
  import dtao_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg.on_time_ms    <= ON_TIME_MS_RST;
      cfg.invert_input  <= 1'b0;
      cfg.invert_output <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE_MS:   cfg.debounce_ms   <= wr_data[15:0];
        REG_ON_TIME_MS:    cfg.on_time_ms    <= wr_data[31:0];
        REG_INVERT_INPUT:  cfg.invert_input  <= wr_data[0];
        REG_INVERT_OUTPUT: cfg.invert_output <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dtao_core.sv
// per-poll state update: debounce, edge toggle and auto-off timer
// depends on dtao_pkg
`default_nettype none

module dtao_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire dtao_pkg::dtao_in_t  poll,
  input  wire dtao_pkg::dtao_cfg_t cfg,
  output dtao_pkg::dtao_out_t result_next
);
  import dtao_pkg::*;

  logic        press_qualified, press_qualified_next;
  logic        prior_press, prior_press_next;
  logic        toggle_latch, toggle_latch_next;
  logic        light_on, light_on_next;
  logic [31:0] held_time, held_time_next;
  logic [31:0] lit_time, lit_time_next;
  logic        timer_running, timer_running_next;

  logic        pressed;
  logic [31:0] held_sum;
  logic [31:0] lit_sum;
  logic        pulse;

  always_comb begin
    pressed  = poll.raw_level ^ cfg.invert_input;
    held_sum = sat_add(held_time, poll.elapsed_ms);
    lit_sum  = timer_running ? sat_add(lit_time, poll.elapsed_ms) : lit_time;

    prior_press_next   = prior_press;
    toggle_latch_next  = toggle_latch;
    light_on_next      = light_on;
    lit_time_next      = lit_sum;
    timer_running_next = timer_running;
    pulse              = 1'b0;

    if (pressed) begin
      held_time_next       = held_sum;
      press_qualified_next = press_qualified | (held_sum > {16'b0, cfg.debounce_ms});
    end else begin
      held_time_next       = '0;
      press_qualified_next = 1'b0;
    end
    if (poll.remote_press) begin
      press_qualified_next = 1'b1;
    end

    if (press_qualified_next) begin
      if (!prior_press) begin
        prior_press_next = 1'b1;
        pulse            = 1'b1;
        if (!toggle_latch) begin
          light_on_next      = 1'b1;
          toggle_latch_next  = 1'b1;
          lit_time_next      = '0;
          timer_running_next = 1'b1;
        end else begin
          light_on_next     = 1'b0;
          toggle_latch_next = 1'b0;
        end
      end
    end else begin
      prior_press_next = 1'b0;
      if (light_on && timer_running && (lit_sum > cfg.on_time_ms)) begin
        light_on_next      = 1'b0;
        toggle_latch_next  = 1'b0;
        timer_running_next = 1'b0;
        lit_time_next      = '0;
      end
    end

    result_next.light_drive     = light_on_next ^ cfg.invert_output;
    result_next.toggle_pulse    = pulse;
    result_next.debounced_press = press_qualified_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_qualified <= 1'b0;
      prior_press     <= 1'b0;
      toggle_latch    <= 1'b0;
      light_on        <= 1'b0;
      held_time       <= '0;
      lit_time        <= '0;
      timer_running   <= 1'b0;
    end else if (accept) begin
      press_qualified <= press_qualified_next;
      prior_press     <= prior_press_next;
      toggle_latch    <= toggle_latch_next;
      light_on        <= light_on_next;
      held_time       <= held_time_next;
      lit_time        <= lit_time_next;
      timer_running   <= timer_running_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dtao_out_stage.sv
// result register with valid/stall handshake toward the consumer
// depends on dtao_pkg
`default_nettype none

module dtao_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire dtao_pkg::dtao_out_t result_next,
  output logic               result_valid,
  input  wire logic          result_stall,
  output dtao_pkg::dtao_out_t result
);
  import dtao_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/debounced_toggle_auto_off_top.sv
// top level of the debounced push-button toggle with auto-off timer
// depends on dtao_pkg, dtao_cfg_regs, dtao_core, dtao_out_stage and the assert header
//
// channel  | direction | handshake          | beat
// poll     | in        | poll_valid/stall   | raw_level, remote_press, elapsed_ms
// result   | out       | result_valid/stall | light_drive, toggle_pulse, debounced_press
// cfg      | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// one poll per clock unless stalled; its result appears in the result register in the cycle after acceptance
// the poll is stalled during reset and while a result is held and the consumer stalls it
// cfg_ready is always high; a write takes effect on the next cycle
// rst is synchronous and clears the state, registers go to their reset values; the result data register is not reset
`default_nettype none

`include "debounced_toggle_auto_off_top_assert.svh"

module debounced_toggle_auto_off_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           poll_valid,
  output logic                                poll_stall,
  input  wire dtao_pkg::dtao_in_t             poll,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output dtao_pkg::dtao_out_t                 result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dtao_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtao_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtao_pkg::*;

  dtao_cfg_t cfg;
  dtao_out_t result_next;
  logic      accept;

  assign cfg_ready  = 1'b1;
  assign poll_stall = rst | (result_valid & result_stall);
  assign accept     = poll_valid & ~poll_stall;

  dtao_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dtao_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .poll        (poll),
    .cfg         (cfg),
    .result_next (result_next)
  );

  dtao_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .result_next  (result_next),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `DTAO_ASSERT_NXT(a_poll_gives_result, clk, rst, accept, result_valid)
  `DTAO_ASSERT_NXT(a_remote_qualifies, clk, rst, accept && poll.remote_press, result.debounced_press)
  `DTAO_ASSERT_IMP(a_pulse_needs_press, clk, rst, result_valid && result.toggle_pulse, result.debounced_press)

endmodule

`default_nettype wire
